// ----- sv/hfe_pkg.sv -----
// ---------------------------------------------------------------------------
// hfe_pkg
// Shared types and constants of the HDLC frame bit encoder.
// ---------------------------------------------------------------------------
package hfe_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_FLAG  = 2'd1,
    OP_DATA  = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] frame_byte;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic last;
  } out_item_t;

  // serializer status toward the top level
  typedef struct packed {
    logic busy;     // bits still to send for the loaded request
    logic emit;     // a bit goes to the output register this cycle
    logic ref_bit;  // the bit emitted is the start reference bit
    logic level;    // line level of the emitted bit
    logic last;     // emitted bit is the request's final bit
  } ser_status_t;

  localparam int          JOB_W     = 24;
  localparam int          CNT_W     = 5;
  localparam int          ONES_W    = 3;
  localparam int          STUFF_RUN = 5;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;
  localparam logic [15:0] FCS_POLY  = 16'h8408;
  // flag 0,1,1,1,1,1,1,0 sent lsb first
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;

  // reflected crc-16/x.25 over one byte
  function automatic logic [15:0] fcs_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/hdlc_frame_bit_encoder.sv -----
// ---------------------------------------------------------------------------
// hdlc_frame_bit_encoder
// HDLC/AX.25 transmit bit engine: frame requests in, NRZI line bits out.
// ---------------------------------------------------------------------------
// usage
//   in channel : one request per frame command (start, flag, data byte, end),
//                taken at a clock edge with in_valid high and in_stall low
//   out channel: one NRZI line bit per handshake, last set on the final bit
//                that a command produces
//   path       : a request is loaded into the shift register, and its bits
//                go from there to the output register
//   throughput : one line bit per cycle while the output is not stalled; the
//                line bits per request are start 1, flag 8, data 8 to 10,
//                end 24 to 28. the shift register is the limit: the next
//                request is taken in the cycle the final bit is registered
//   reset      : fcs = 0xffff, line level 1, ones run 0, nothing pending
//   stall      : when out_stall holds the output register, the shifter
//                freezes and in_stall stays high while a job is loaded; an
//                idle shifter still takes one request and then holds it
// ---------------------------------------------------------------------------
module hdlc_frame_bit_encoder
  import hfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_item_r;
  logic        adv;
  logic        load;
  logic [15:0] fcs_inv;
  ser_status_t ser_st;

  // output slot can take a new bit
  assign adv = !out_valid_r || !out_stall;

  // take a request when idle or when the final bit of the current one leaves
  assign in_stall = ser_st.busy && !(ser_st.emit && ser_st.last);
  assign load     = in_valid && !in_stall;

  hfe_fcs u_fcs (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .item    (in_item),
    .fcs_inv (fcs_inv)
  );

  hfe_serializer u_ser (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .load    (load),
    .item    (in_item),
    .fcs_inv (fcs_inv),
    .status  (ser_st)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = ser_st.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_st.emit) begin
      out_item_r.line_level <= ser_st.level;
      out_item_r.last       <= ser_st.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // start request loads a job that the engine then works on
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_item.op == OP_START) |=> ser_st.busy)
    else $error("start request did not load a job");

  // reference bit is a single level-one bit that ends its request
  a_ref_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_st.emit && ser_st.ref_bit) |-> (ser_st.level && ser_st.last))
    else $error("reference bit not level one or not last");

  // end request sends at least fcs and flag, so its first bit is never last
  a_end_long: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_item.op == OP_END) |=> !(ser_st.emit && ser_st.last))
    else $error("end request finished too early");

endmodule

// ----- sv/hfe_fcs.sv -----
// ---------------------------------------------------------------------------
// hfe_fcs
// Frame check sequence register, updated once per accepted request.
// ---------------------------------------------------------------------------
module hfe_fcs
  import hfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  in_item_t    item,
  output logic [15:0] fcs_inv
);

  logic [15:0] fcs_r;
  logic [15:0] fcs_nxt;

  always_comb begin
    fcs_nxt = fcs_r;
    if (load) begin
      unique case (item.op)
        OP_START: fcs_nxt = FCS_INIT;
        OP_FLAG:  fcs_nxt = fcs_r;
        OP_DATA:  fcs_nxt = fcs_byte(fcs_r, item.frame_byte);
        OP_END:   fcs_nxt = FCS_INIT;
        default:  fcs_nxt = fcs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcs_r <= FCS_INIT;
    end else begin
      fcs_r <= fcs_nxt;
    end
  end

  // transmitted fcs is the complement of the running value
  assign fcs_inv = ~fcs_r;

endmodule

// ----- sv/hfe_serializer.sv -----
// ---------------------------------------------------------------------------
// hfe_serializer
// Bit shifter with zero stuffing and nrzi coding, one line bit per cycle while adv is high.
// ---------------------------------------------------------------------------
module hfe_serializer
  import hfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        load,
  input  in_item_t    item,
  input  logic [15:0] fcs_inv,
  output ser_status_t status
);

  localparam logic [ONES_W-1:0] STUFF_AT = ONES_W'(STUFF_RUN - 1);

  logic [JOB_W-1:0]  sh_r,    sh_nxt;
  logic [JOB_W-1:0]  mask_r,  mask_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic              ref_r,   ref_nxt;
  logic              stuff_r, stuff_nxt;
  logic [ONES_W-1:0] ones_r,  ones_nxt;
  logic              line_r,  line_nxt;
  logic              busy;
  logic              emit;
  logic              last;

  assign busy = (cnt_r != '0) || stuff_r;
  assign emit = adv && busy;

  always_comb begin
    sh_nxt    = sh_r;
    mask_nxt  = mask_r;
    cnt_nxt   = cnt_r;
    ref_nxt   = ref_r;
    stuff_nxt = stuff_r;
    ones_nxt  = ones_r;
    line_nxt  = line_r;
    last      = 1'b0;

    if (emit) begin
      if (stuff_r) begin
        // inserted zero after a run of ones
        line_nxt  = ~line_r;
        ones_nxt  = '0;
        stuff_nxt = 1'b0;
        last      = (cnt_r == '0);
      end else begin
        sh_nxt   = sh_r >> 1;
        mask_nxt = mask_r >> 1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        ref_nxt  = 1'b0;
        if (ref_r) begin
          line_nxt = 1'b1;
        end else if (!sh_r[0]) begin
          line_nxt = ~line_r;
        end
        if (mask_r[0] && sh_r[0]) begin
          if (ones_r == STUFF_AT) begin
            stuff_nxt = 1'b1;
            ones_nxt  = '0;
          end else begin
            ones_nxt = ones_r + ONES_W'(1);
          end
        end else begin
          ones_nxt = '0;
        end
        last = (cnt_r == CNT_W'(1)) && !stuff_nxt;
      end
    end

    if (load) begin
      ref_nxt = 1'b0;
      unique case (item.op)
        OP_START: begin
          sh_nxt   = JOB_W'(1);
          mask_nxt = '0;
          cnt_nxt  = CNT_W'(1);
          ref_nxt  = 1'b1;
        end
        OP_FLAG: begin
          sh_nxt   = JOB_W'(FLAG_BYTE);
          mask_nxt = '0;
          cnt_nxt  = CNT_W'(8);
        end
        OP_DATA: begin
          sh_nxt   = JOB_W'(item.frame_byte);
          mask_nxt = JOB_W'(8'hFF);
          cnt_nxt  = CNT_W'(8);
        end
        OP_END: begin
          sh_nxt   = {FLAG_BYTE, fcs_inv};
          mask_nxt = JOB_W'(16'hFFFF);
          cnt_nxt  = CNT_W'(JOB_W);
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ref_r   <= 1'b0;
      stuff_r <= 1'b0;
      ones_r  <= '0;
      line_r  <= 1'b1;
    end else begin
      cnt_r   <= cnt_nxt;
      ref_r   <= ref_nxt;
      stuff_r <= stuff_nxt;
      ones_r  <= ones_nxt;
      line_r  <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    mask_r <= mask_nxt;
  end

  assign status.busy    = busy;
  assign status.emit    = emit;
  assign status.ref_bit = ref_r && !stuff_r;
  assign status.level   = line_nxt;
  assign status.last    = last;

endmodule

// ----- bench/hfe_bit_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hfe_bit_checker
// Watches the request and line-bit channels of the HDLC frame bit encoder,
// predicts the NRZI bits of each accepted request and compares them in order.
// ---------------------------------------------------------------------------
module hfe_bit_checker
  import hfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  input  logic      drain_check,
  output int        pending,
  output int        fail_count
);

  // predicted encoder state
  logic [15:0] fcs_reg;
  logic        line_lvl;
  logic [2:0]  ones_cnt;

  out_item_t expected_bits[$];
  int        bit_index;
  bit        drain_seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // nrzi: a zero toggles the line, a one keeps it
  function automatic void put_line_bit(input logic b);
    out_item_t r;
    if (!b) line_lvl = ~line_lvl;
    r.line_level = line_lvl;
    r.last       = 1'b0;
    expected_bits.push_back(r);
  endfunction

  function automatic void put_stuffed_byte(input logic [7:0] v);
    for (int i = 0; i < 8; i++) begin
      put_line_bit(v[i]);
      if (v[i]) begin
        ones_cnt = ones_cnt + 3'd1;
        if (ones_cnt == 3'(STUFF_RUN)) begin
          put_line_bit(1'b0);
          ones_cnt = '0;
        end
      end else begin
        ones_cnt = '0;
      end
    end
  endfunction

  function automatic void put_flag_bits();
    for (int i = 0; i < 8; i++) put_line_bit(FLAG_BYTE[i]);
    ones_cnt = '0;
  endfunction

  // bit-serial form of the reflected x.25 crc
  function automatic logic [15:0] crc_after(input logic [15:0] acc, input logic [7:0] v);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ v[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ FCS_POLY;
    end
    return acc;
  endfunction

  function automatic void encode_request(input in_item_t req);
    logic [15:0] inv;
    out_item_t   tail;
    case (req.op)
      OP_START: begin
        fcs_reg  = FCS_INIT;
        ones_cnt = '0;
        line_lvl = 1'b1;
        put_line_bit(1'b1);
      end
      OP_FLAG: put_flag_bits();
      OP_DATA: begin
        fcs_reg = crc_after(fcs_reg, req.frame_byte);
        put_stuffed_byte(req.frame_byte);
      end
      OP_END: begin
        inv = ~fcs_reg;
        put_stuffed_byte(inv[7:0]);
        put_stuffed_byte(inv[15:8]);
        put_flag_bits();
        fcs_reg  = FCS_INIT;
        ones_cnt = '0;
      end
      default: ;
    endcase
    if (expected_bits.size() != 0) begin
      tail      = expected_bits.pop_back();
      tail.last = 1'b1;
      expected_bits.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fcs_reg    = FCS_INIT;
      line_lvl   = 1'b1;
      ones_cnt   = '0;
      bit_index  = 0;
      fail_count = 0;
      drain_seen = 1'b0;
      expected_bits.delete();
    end else begin
      // results first, so a bit can never match a request taken in the same cycle
      if (out_valid && !out_stall) begin
        if (expected_bits.size() == 0) begin
          report_mismatch($sformatf("line bit %0d arrived with none expected", bit_index));
        end else begin
          want = expected_bits.pop_front();
          if (out_item.line_level !== want.line_level)
            report_mismatch($sformatf("line bit %0d: level %b, expected %b",
                                      bit_index, out_item.line_level, want.line_level));
          if (out_item.last !== want.last)
            report_mismatch($sformatf("line bit %0d: last %b, expected %b",
                                      bit_index, out_item.last, want.last));
        end
        bit_index++;
      end
      if (in_valid && !in_stall) encode_request(in_item);
      if (drain_check && !drain_seen) begin
        drain_seen = 1'b1;
        if (expected_bits.size() != 0)
          report_mismatch($sformatf("%0d line bits never arrived", expected_bits.size()));
      end
    end
    pending = expected_bits.size();
  end

endmodule

// ----- bench/tb_hdlc_frame_bit_encoder.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_hdlc_frame_bit_encoder
// Drives frame requests into the HDLC frame bit encoder, first a directed set
// of corner cases, then random frames mixed with stray commands, with random
// gaps and output stalls; a checker beside the block predicts every line bit.
// ---------------------------------------------------------------------------
module tb_hdlc_frame_bit_encoder;
  import hfe_pkg::*;

  localparam int RANDOM_ITEMS   = 350;
  localparam int QUIET_ITEMS    = 60;   // final stretch with no gaps or stalls
  localparam int PRESSURE_AT    = 150;  // random request count that triggers the long hold
  localparam int LONG_HOLD      = 400;  // cycles of receiver hold-off
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      drain_check;

  int pending;
  int fail_count;
  int sent;         // requests accepted so far
  int hold_asked;   // long holds requested from the receiver side
  int idle_cycles;
  bit quiet;        // no gaps and no stalls from here on

  hdlc_frame_bit_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  hfe_bit_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .drain_check (drain_check),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // present one request and hold it until taken; valid stays high between
  // back-to-back requests and only drops for a gap
  task automatic send_request(input op_t code, input logic [7:0] val);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{op: code, frame_byte: val};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // data bytes leaning toward long runs of ones so stuffing happens often
  function automatic logic [7:0] pick_byte();
    logic [7:0] ones_heavy[6] = '{8'hFF, 8'hFE, 8'h7F, 8'hF8, 8'h1F, 8'h3E};
    if ($urandom_range(0, 3) == 0) return ones_heavy[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  // well-formed frame: start, opening flags, payload, fcs with closing flag
  task automatic send_frame(input int n_bytes);
    send_request(OP_START, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(1, 3)) send_request(OP_FLAG, 8'($urandom_range(0, 255)));
    repeat (n_bytes) send_request(OP_DATA, pick_byte());
    send_request(OP_END, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 0) send_request(OP_FLAG, 8'($urandom_range(0, 255)));
  endtask

  // receiver side: random stall bursts, open stretches, and one long hold
  initial begin
    int hold_given;
    hold_given = 0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_asked > hold_given) begin
        hold_given++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // watchdog: too long without any request or line bit taken
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_hdlc_frame_bit_encoder: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  target;
    bit  pressure_done;
    sent          = 0;
    hold_asked    = 0;
    quiet         = 1'b0;
    pressure_done = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_item     <= '0;
    drain_check <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // commands before any start run on the reset state; ones carry across bytes
    send_request(OP_DATA, 8'hFF);
    send_request(OP_DATA, 8'h00);
    // the byte field is ignored outside data requests
    send_request(OP_FLAG, 8'hFF);
    send_request(OP_END, 8'h00);
    send_request(OP_START, 8'hA5);
    send_request(OP_FLAG, 8'h00);
    send_request(OP_DATA, 8'h00);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_DATA, 8'h1F);   // exactly five ones
    send_request(OP_DATA, 8'hF8);
    send_request(OP_DATA, 8'h7E);   // flag pattern as data gets stuffed
    send_request(OP_END, 8'hFF);
    // empty frame: inverted fcs is all zeros
    send_request(OP_START, 8'h5A);
    send_request(OP_END, 8'hC3);
    // ones run spanning several bytes, then fcs and a trailing flag
    send_request(OP_START, 8'h00);
    send_request(OP_FLAG, 8'h00);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_END, 8'h00);
    send_request(OP_FLAG, 8'hFF);

    // random part: mostly whole frames, some stray commands
    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      if (sent >= target - QUIET_ITEMS) quiet = 1'b1;
      if (!pressure_done && sent >= target - RANDOM_ITEMS + PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_asked++;
      end
      if ($urandom_range(0, 4) == 0)
        send_request(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      else
        send_frame($urandom_range(0, 12));
    end
    in_valid <= 1'b0;

    // drain, then give a stray bit time to show up
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    drain_check <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_hdlc_frame_bit_encoder: done, clean");
    end else begin
      $display("tb_hdlc_frame_bit_encoder: done, errors");
    end
    $finish;
  end

endmodule
